// ===== hdl/kmer_window_hash_defines.svh =====
// Assertion macros shared by the k-mer hash RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef KMER_WINDOW_HASH_DEFINES_SVH
`define KMER_WINDOW_HASH_DEFINES_SVH

// Condition holds on every clock edge out of reset.
`define KWH_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("kwh assertion failed");

// Same-cycle implication.
`define KWH_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kwh assertion failed");

// Next-cycle implication.
`define KWH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kwh assertion failed");

`endif

// ===== hdl/kwh_pkg.sv =====
// Shared constants and base encoding for the k-mer window hash.
// No dependencies.
package kwh_pkg;

	localparam int CHAR_W = 8;
	localparam int OUT_W  = 56;

	localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
	localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
	localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

	typedef logic [1:0] base_code_t;

	localparam base_code_t BASE_A = 2'd0;
	localparam base_code_t BASE_C = 2'd1;
	localparam base_code_t BASE_G = 2'd2;
	localparam base_code_t BASE_T = 2'd3;

	localparam int MIX_SH1 = 21;
	localparam int MIX_SH2 = 24;
	localparam int MIX_SH3 = 3;
	localparam int MIX_SH4 = 8;
	localparam int MIX_SH5 = 14;
	localparam int MIX_SH6 = 2;
	localparam int MIX_SH7 = 4;
	localparam int MIX_SH8 = 28;
	localparam int MIX_SH9 = 31;

	typedef logic [OUT_W-1:0] hash_word_t;

	function automatic base_code_t encode_base(input logic [CHAR_W-1:0] ch);
		base_code_t code;
		unique case (ch)
			CHAR_A: code = BASE_A;
			CHAR_C: code = BASE_C;
			CHAR_G: code = BASE_G;
			CHAR_T: code = BASE_T;
			default: code = BASE_A;
		endcase
		return code;
	endfunction

endpackage

// ===== hdl/kmer_window_hash.sv =====
// kmer_window_hash: takes one ASCII base per transfer (A, C, G, T; anything else
// counts as A) into a rolling window of KMER_LEN bases and, once KMER_LEN bases
// of the current sequence have arrived, returns the masked integer hash of the
// window for that base and each later one. start_of_sequence clears the window
// first. One base per cycle while base_ready is high; the combinational window
// update and hash feed the result register, and a skid entry lets a base be
// taken while a result waits, dropping base_ready once full. Depends on kwh_pkg.
module kmer_window_hash import kwh_pkg::*; #(
	parameter int KMER_LEN = 28
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              base_valid,
	output logic              base_ready,
	input  logic [CHAR_W-1:0] base_char,
	input  logic              start_of_sequence,
	output logic              hash_valid,
	input  logic              hash_ready,
	output logic [OUT_W-1:0]  kmer_hash
);

	localparam int WIN_W = 2 * KMER_LEN;
	localparam int EXT_W = (WIN_W > OUT_W) ? WIN_W : OUT_W;

	logic             take;
	logic             full;
	logic [WIN_W-1:0] win_next;
	logic [WIN_W-1:0] mix_hash;
	logic [EXT_W-1:0] hash_ext;
	hash_word_t       hash_word;

	assign take      = base_valid && base_ready;
	assign hash_ext  = EXT_W'(mix_hash);
	assign hash_word = hash_ext[OUT_W-1:0];

	kwh_window #(
		.KMER_LEN(KMER_LEN)
	) u_window (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (take),
		.base_char        (base_char),
		.start_of_sequence(start_of_sequence),
		.win_next         (win_next),
		.full             (full)
	);

	kwh_mix #(
		.WIN_W(WIN_W)
	) u_mix (
		.win (win_next),
		.hash(mix_hash)
	);

	kwh_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && full),
		.push_data (hash_word),
		.push_ready(base_ready),
		.out_valid (hash_valid),
		.out_ready (hash_ready),
		.out_data  (kmer_hash)
	);

endmodule

// ===== hdl/kwh_window.sv =====
// Rolling base window and saturating base count.
// Depends on kwh_pkg and kmer_window_hash_defines.svh.
`include "kmer_window_hash_defines.svh"

module kwh_window import kwh_pkg::*; #(
	parameter int KMER_LEN = 28
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [CHAR_W-1:0]     base_char,
	input  logic                  start_of_sequence,
	output logic [2*KMER_LEN-1:0] win_next,
	output logic                  full
);

	localparam int WIN_W = 2 * KMER_LEN;
	localparam int CNT_W = (KMER_LEN > 1) ? $clog2(KMER_LEN) : 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(KMER_LEN - 1);

	logic [WIN_W-1:0] win_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIN_W-1:0] win_base;
	logic [CNT_W-1:0] cnt_base;
	logic [CNT_W-1:0] cnt_next;
	base_code_t       code;

	assign code     = encode_base(base_char);
	assign win_base = start_of_sequence ? '0 : win_q;
	assign cnt_base = start_of_sequence ? '0 : cnt_q;
	assign win_next = (win_base << 2) | WIN_W'(code);
	assign full     = (cnt_base >= CNT_MAX);
	assign cnt_next = full ? CNT_MAX : cnt_base + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			cnt_q <= '0;
		end else if (take) begin
			win_q <= win_next;
			cnt_q <= cnt_next;
		end
	end

	`KWH_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_MAX)
	`KWH_ASSERT_NEXT(a_start_cnt, take && start_of_sequence,
		cnt_q == ((KMER_LEN > 1) ? CNT_W'(1) : CNT_W'(0)))
	`KWH_ASSERT_NEXT(a_newest_base, take, win_q[1:0] == $past(code))

endmodule

// ===== hdl/kwh_mix.sv =====
// Masked shift/add/xor integer hash over the base window.
// Depends on kwh_pkg.
module kwh_mix import kwh_pkg::*; #(
	parameter int WIN_W = 56
) (
	input  logic [WIN_W-1:0] win,
	output logic [WIN_W-1:0] hash
);

	logic [WIN_W-1:0] k1, k2, k3, k4, k5, k6;

	assign k1   = ~win + (win << MIX_SH1);
	assign k2   = k1 ^ (k1 >> MIX_SH2);
	assign k3   = k2 + (k2 << MIX_SH3) + (k2 << MIX_SH4);
	assign k4   = k3 ^ (k3 >> MIX_SH5);
	assign k5   = k4 + (k4 << MIX_SH6) + (k4 << MIX_SH7);
	assign k6   = k5 ^ (k5 >> MIX_SH8);
	assign hash = k6 + (k6 << MIX_SH9);

endmodule

// ===== hdl/kwh_outbuf.sv =====
// Result register with a skid entry; upstream ready is registered.
// Depends on kwh_pkg and kmer_window_hash_defines.svh.
`include "kmer_window_hash_defines.svh"

module kwh_outbuf import kwh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  hash_word_t push_data,
	output logic       push_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output hash_word_t out_data
);

	logic       main_v_q;
	logic       skid_v_q;
	hash_word_t main_d_q;
	hash_word_t skid_d_q;

	assign push_ready = !skid_v_q;
	assign out_valid  = main_v_q;
	assign out_data   = main_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || out_ready) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || out_ready) begin
			main_d_q <= skid_v_q ? skid_d_q : push_data;
		end else if (push) begin
			skid_d_q <= push_data;
		end
	end

	`KWH_ASSERT_IMPL(a_skid_needs_main, skid_v_q, main_v_q)
	`KWH_ASSERT_NEXT(a_stall_fills_skid, push && main_v_q && !out_ready, skid_v_q)
	`KWH_ASSERT_NEXT(a_skid_drains, skid_v_q && out_ready, main_v_q && !skid_v_q)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for kmer_window_hash: streams ASCII bases over valid/ready and
// compares every k-mer hash against an in-bench window and integer-hash predictor.
// Depends on kwh_pkg and the kmer_window_hash RTL.
module testbench import kwh_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int KMER        = 28;
	localparam int WIN_W       = 2 * KMER;
	localparam hash_word_t WIN_MASK = {OUT_W{1'b1}} >> (OUT_W - WIN_W);
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC, RX_LONG_STALL} rx_mode_e;

	logic              clk;
	logic              arst_n;
	logic              base_valid;
	logic              base_ready;
	logic [CHAR_W-1:0] base_char;
	logic              start_of_sequence;
	logic              hash_valid;
	logic              hash_ready;
	logic [OUT_W-1:0]  kmer_hash;

	hash_word_t  expected_hashes[$];
	hash_word_t  kmer_window;
	logic [4:0]  window_fill;

	int errors = 0;
	int bases_sent;
	int sequences_started;
	int hashes_checked = 0;
	int stall_cycles = 0;
	int cycle_count = 0;
	int burst_left;
	bit steady;
	bit valid_up;
	rx_mode_e rx_mode = RX_ALWAYS;

	kmer_window_hash #(.KMER_LEN(KMER)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.base_valid(base_valid),
		.base_ready(base_ready),
		.base_char(base_char),
		.start_of_sequence(start_of_sequence),
		.hash_valid(hash_valid),
		.hash_ready(hash_ready),
		.kmer_hash(kmer_hash)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic base_code_t char_to_code(input logic [CHAR_W-1:0] ch);
		if (ch == CHAR_C)
			return BASE_C;
		if (ch == CHAR_G)
			return BASE_G;
		if (ch == CHAR_T)
			return BASE_T;
		return BASE_A;
	endfunction

	function automatic hash_word_t wang_mix(input hash_word_t w);
		hash_word_t k;
		k = w & WIN_MASK;
		k = (~k + (k << MIX_SH1)) & WIN_MASK;
		k = k ^ (k >> MIX_SH2);
		k = (k + (k << MIX_SH3) + (k << MIX_SH4)) & WIN_MASK;
		k = k ^ (k >> MIX_SH5);
		k = (k + (k << MIX_SH6) + (k << MIX_SH7)) & WIN_MASK;
		k = k ^ (k >> MIX_SH8);
		k = (k + (k << MIX_SH9)) & WIN_MASK;
		return k;
	endfunction

	function automatic void shift_in_base(input logic [CHAR_W-1:0] ch, input logic sos);
		if (sos) begin
			kmer_window = '0;
			window_fill = '0;
		end
		kmer_window = ((kmer_window << 2) | hash_word_t'(char_to_code(ch))) & WIN_MASK;
		if (window_fill >= KMER - 1) begin
			window_fill = 5'(KMER - 1);
			expected_hashes.push_back(wang_mix(kmer_window));
		end else begin
			window_fill = window_fill + 1'b1;
		end
	endfunction

	task automatic drop_valid();
		if (valid_up) begin
			base_valid <= 1'b0;
			valid_up = 1'b0;
		end
	endtask

	task automatic pace_sender();
		int gap;
		if (steady)
			return;
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 6);
			drop_valid();
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 32);
		end
	endtask

	task automatic send_base(input logic [CHAR_W-1:0] ch, input logic sos);
		base_valid <= 1'b1;
		base_char <= ch;
		start_of_sequence <= sos;
		valid_up = 1'b1;
		@(posedge clk);
		while (!base_ready) @(posedge clk);
		shift_in_base(ch, sos);
		bases_sent++;
		if (sos)
			sequences_started++;
		pace_sender();
	endtask

	task automatic wait_for_hashes();
		drop_valid();
		while (expected_hashes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CHAR_W-1:0] random_char();
		int r;
		logic [CHAR_W-1:0] bases[4];
		logic [CHAR_W-1:0] odd[5];
		bases = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};
		odd = '{8'h61, 8'h63, 8'h67, 8'h74, 8'h4E};
		r = $urandom_range(0, 99);
		if (r < 85)
			return bases[$urandom_range(0, 3)];
		if (r < 93)
			return odd[$urandom_range(0, 4)];
		return CHAR_W'($urandom_range(0, 255));
	endfunction

	// start flag on the very first item, byte extremes, lower case, near-miss letters
	task automatic test_first_sequence();
		logic [CHAR_W-1:0] edge_chars[16];
		logic [CHAR_W-1:0] ch;
		logic [CHAR_W-1:0] bases[4];
		edge_chars = '{8'h00, 8'hFF, 8'h61, 8'h63, 8'h67, 8'h74, CHAR_A, CHAR_C,
			CHAR_G, CHAR_T, 8'h4E, 8'h80, 8'h7F, 8'h40, 8'h42, 8'h55};
		bases = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};
		steady = 1'b0;
		for (int i = 0; i < KMER + 1; i++) begin
			ch = (i < 16) ? edge_chars[i] : bases[i % 4];
			send_base(ch, i == 0);
		end
	endtask

	// restart while the window is full, then a short sequence that must stay silent
	task automatic test_restart();
		send_base(CHAR_T, 1'b1);
		send_base(CHAR_C, 1'b0);
		send_base(CHAR_G, 1'b1);
		wait_for_hashes();
	endtask

	// window state must survive the sender idling until the output is empty
	task automatic test_pause_for_drain();
		send_base(random_char(), 1'b1);
		for (int i = 0; i < 40; i++)
			send_base(random_char(), 1'b0);
		wait_for_hashes();
		for (int i = 0; i < 12; i++)
			send_base(random_char(), 1'b0);
	endtask

	task automatic test_random_sequences(input int target);
		int len;
		int r;
		int stop_at;
		stop_at = bases_sent + target;
		while (bases_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				len = $urandom_range(1, KMER - 1);
			else if (r < 90)
				len = $urandom_range(KMER, 70);
			else
				len = $urandom_range(71, 140);
			steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < len; i++)
				send_base(random_char(), i == 0);
		end
		steady = 1'b0;
	endtask

	task automatic test_noise(input int count);
		for (int i = 0; i < count; i++)
			send_base(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count % 97 == 0)
			rx_mode = rx_mode_e'($urandom_range(0, 4));
		if (!arst_n) begin
			hash_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS:     hash_ready <= 1'b1;
				RX_COIN:       hash_ready <= ($urandom_range(0, 1) != 0);
				RX_MOSTLY:     hash_ready <= ($urandom_range(0, 3) != 0);
				RX_PERIODIC:   hash_ready <= (cycle_count % 5 != 0);
				RX_LONG_STALL: hash_ready <= (cycle_count % 16 > 11);
				default:       hash_ready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin : check_hashes
		hash_word_t want;
		if (arst_n && hash_valid && !hash_ready)
			stall_cycles++;
		if (arst_n && hash_valid && hash_ready) begin
			if (expected_hashes.size() == 0) begin
				errors++;
				$display("%0t: unexpected hash, expected none, actual %h", $time, kmer_hash);
			end else begin
				want = expected_hashes.pop_front();
				hashes_checked++;
				if (kmer_hash !== want) begin
					errors++;
					$display("%0t: kmer_hash mismatch, expected %h, actual %h",
						$time, want, kmer_hash);
				end
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		bases_sent = 0;
		sequences_started = 0;
		burst_left = 8;
		steady = 1'b0;
		valid_up = 1'b0;
		kmer_window = '0;
		window_fill = '0;
		arst_n <= 1'b0;
		base_valid <= 1'b0;
		base_char <= '0;
		start_of_sequence <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_sequence();
		test_restart();
		test_pause_for_drain();
		test_random_sequences(800);
		test_noise(90);

		wait_for_hashes();
		$display("Sent %0d bases in %0d sequences; checked %0d hashes, %0d output stall cycles.",
			bases_sent, sequences_started, hashes_checked, stall_cycles);
		if (errors == 0 && expected_hashes.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
